### sv/ptd_pkg.sv
// Package for the periodic task dispatcher.
// Holds the sequencer state type, command, status and register codes, and the ALU request.
// No dependencies.
package ptd_pkg;

    // Commands carried in the input tuser
    localparam logic [1:0] CMD_SET   = 2'd0;
    localparam logic [1:0] CMD_EN    = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;
    localparam logic [1:0] CMD_QUERY = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_DONE   = 2'd0;
    localparam logic [1:0] ST_NOCHG  = 2'd1;
    localparam logic [1:0] ST_BADIDX = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_GUARD  = 3'd0;
    localparam logic [2:0] REG_WINDOW = 3'd1;
    localparam logic [2:0] REG_LOOP   = 3'd2;
    localparam logic [2:0] REG_ATT    = 3'd3;
    localparam logic [2:0] REG_SYS    = 3'd4;

    // Reset values
    localparam logic [15:0] GUARD_RESET  = 16'd400;
    localparam logic [15:0] WINDOW_RESET = 16'd1000;
    localparam logic [3:0]  LOOP_RESET   = 4'd0;
    localparam logic [3:0]  ATT_RESET    = 4'd1;
    localparam logic [3:0]  SYS_RESET    = 4'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_L_SUM,
        S_L_DIFF,
        S_L_GUARD,
        S_L_WIN,
        S_L_RUN,
        S_W_FETCH,
        S_W_SUB,
        S_W_CMP,
        S_SCAN,
        S_SHIFT_INS,
        S_SHIFT_DEL,
        S_DONE
    } state_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef struct packed {
        alu_op_t     op;
        logic [31:0] a;
        logic [31:0] b;
    } alu_req_t;

endpackage

### sv/ptd_alu.sv
// Shared 32-bit add/subtract unit of the periodic task dispatcher.
// Depends on ptd_pkg for the request struct.
module ptd_alu
    import ptd_pkg::*;
(
    input  alu_req_t    req,
    output logic [31:0] y,
    output logic        borrow
);

    logic [32:0] sum33;

    // Add or subtract with a carry bit; borrow means a < b on subtract
    always_comb
    begin
        if (req.op == ALU_ADD)
        begin
            sum33 = {1'b0, req.a} + {1'b0, req.b};
        end
        else
        begin
            sum33 = {1'b0, req.a} - {1'b0, req.b};
        end
    end

    assign y      = sum33[31:0];
    assign borrow = (req.op == ALU_SUB) & sum33[32];

endmodule

### sv/periodic_task_dispatcher.sv
// Top level of the periodic task dispatcher: task table, run queue and sequencer.
// Depends on ptd_pkg and ptd_alu.
//
//  channel | direction | handshake          | payload
//  s_*     | in        | s_tvalid/s_tready  | tuser: cmd; tdata: task fields, now_us
//  m_*     | out       | m_tvalid/m_tready  | tdata: status, chosen, flags, period, delta
//  cfg_*   | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// A tick walks the queued tasks in order, and an insert scans the queue and then shifts
// it to open a slot; the shared adder and one queue slot access per cycle set the pace
// of these walks.
// Reset (asynchronous) loads the register defaults, clears the table and puts task 2
// in the queue. A result waits in the output register; the next item is taken meanwhile,
// and its result holds in the sequencer until the output register frees.
module periodic_task_dispatcher
    import ptd_pkg::*;
#(
    parameter int NUM_TASKS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,  // task_index[3:0], enable[4], period_us[36:5],
                                  // priority_req[44:37], runnable[45], now_us[77:46], zero
    input  logic [1:0]  s_tuser,  // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,  // status[1:0], chosen_task[5:2], dispatched[6],
                                  // queued[7], task_period_us[39:8], latest_delta_us[71:40]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    localparam int DEPTH = (NUM_TASKS < 16) ? NUM_TASKS : 16;
    localparam int IW    = $clog2(DEPTH);
    localparam int QW    = $clog2(DEPTH + 1);
    localparam logic [QW-1:0] LEN_RESET = (2 < DEPTH) ? QW'(1) : QW'(0);

    // Configuration
    logic [15:0] guard_reg, window_reg;
    logic [3:0]  loop_reg, att_reg;

    // Task table and run queue
    logic [31:0]   period_reg [DEPTH];
    logic [7:0]    prio_reg   [DEPTH];
    logic          runm_reg   [DEPTH];
    logic [31:0]   lastrun_reg[DEPTH];
    logic [31:0]   intv_reg   [DEPTH];
    logic [IW-1:0] queue_reg  [DEPTH];
    logic [QW-1:0] len_reg;

    logic [31:0]   period_next [DEPTH];
    logic [7:0]    prio_next   [DEPTH];
    logic          runm_next   [DEPTH];
    logic [31:0]   lastrun_next[DEPTH];
    logic [31:0]   intv_next   [DEPTH];
    logic [IW-1:0] queue_next  [DEPTH];
    logic [QW-1:0] len_next;

    // Sequencer and latched item
    state_t      state_reg, state_next;
    logic [1:0]  cmd_reg, cmd_next;
    logic [3:0]  t_reg, t_next;
    logic        en_reg, en_next;
    logic [31:0] per_reg, per_next;
    logic [7:0]  pri_reg, pri_next;
    logic        run_reg, run_next;
    logic [31:0] now_reg, now_next;

    logic [QW-1:0] idx_reg, idx_next;
    logic [QW-1:0] pos_reg, pos_next;
    logic          found_reg, found_next;
    logic          ins_reg, ins_next;
    logic [7:0]    prit_reg, prit_next;
    logic [31:0]   acc_reg, acc_next;
    logic          skip_reg, skip_next;
    logic [IW-1:0] k_reg, k_next;

    // Pending result
    logic [1:0]  rstat_reg, rstat_next;
    logic [3:0]  rchos_reg, rchos_next;
    logic        rdisp_reg, rdisp_next;
    logic        rq_reg, rq_next;
    logic [31:0] rper_reg, rper_next;
    logic [31:0] rdel_reg, rdel_next;

    // Output register
    logic        oval_reg, oval_next;
    logic [71:0] odata_reg, odata_next;

    logic          accept, out_free;
    logic [IW-1:0] addr, qk;
    logic          t_bad, loop_bad;
    alu_req_t      alu_req;
    logic [31:0]   alu_y;
    logic          alu_borrow;

    assign accept    = s_tvalid & s_tready;
    assign out_free  = ~oval_reg | m_tready;
    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = oval_reg;
    assign m_tdata   = odata_reg;

    assign t_bad    = (int'(t_reg) >= NUM_TASKS);
    assign loop_bad = (int'(loop_reg) >= NUM_TASKS);
    assign qk       = queue_reg[idx_reg[IW-1:0]];

    ptd_alu u_alu (
        .req    (alu_req),
        .y      (alu_y),
        .borrow (alu_borrow)
    );

    // Select the one table row read this cycle
    always_comb
    begin
        unique case (state_reg)
            S_L_SUM, S_L_RUN:   addr = IW'(loop_reg);
            S_W_SUB, S_W_CMP:   addr = k_reg;
            S_SCAN:             addr = qk;
            default:            addr = IW'(t_reg);
        endcase
    end

    // Feed the shared adder
    always_comb
    begin
        alu_req.op = ALU_SUB;
        alu_req.a  = now_reg;
        alu_req.b  = lastrun_reg[addr];
        unique case (state_reg)
            S_L_SUM:
            begin
                alu_req.op = ALU_ADD;
                alu_req.a  = lastrun_reg[addr];
                alu_req.b  = period_reg[addr];
            end
            S_L_DIFF:
            begin
                alu_req.a = acc_reg;
                alu_req.b = now_reg;
            end
            S_L_GUARD:
            begin
                alu_req.a = {16'd0, guard_reg};
                alu_req.b = acc_reg;
            end
            S_L_WIN:
            begin
                alu_req.a = acc_reg;
                alu_req.b = {16'd0, window_reg};
            end
            S_W_CMP:
            begin
                alu_req.a = acc_reg;
                alu_req.b = period_reg[addr];
            end
            default:
            begin
                alu_req.op = ALU_SUB;
            end
        endcase
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (accept)
                    state_next = S_DECODE;
            S_DECODE:
            begin
                if (cmd_reg == CMD_TICK)
                    state_next = loop_bad ? S_DONE : S_L_SUM;
                else if (t_bad || cmd_reg == CMD_SET)
                    state_next = S_DONE;
                else if (cmd_reg == CMD_EN && en_reg && runm_reg[addr] && len_reg >= QW'(DEPTH))
                    state_next = S_DONE;
                else
                    state_next = S_SCAN;
            end
            S_L_SUM:
                state_next = S_L_DIFF;
            S_L_DIFF:
                state_next = (alu_y == 32'd0 || alu_y[31]) ? S_L_RUN : S_L_GUARD;
            S_L_GUARD:
                state_next = alu_borrow ? S_L_WIN : S_DONE;
            S_L_WIN:
                state_next = S_W_FETCH;
            S_L_RUN:
                state_next = S_DONE;
            S_W_FETCH:
            begin
                if (idx_reg == len_reg)
                    state_next = S_DONE;
                else if (!(skip_reg && 4'(qk) == att_reg))
                    state_next = S_W_SUB;
            end
            S_W_SUB:
                state_next = S_W_CMP;
            S_W_CMP:
                state_next = alu_borrow ? S_W_FETCH : S_DONE;
            S_SCAN:
            begin
                if (idx_reg == len_reg)
                begin
                    if (cmd_reg == CMD_EN && ins_reg && pos_reg != len_reg)
                        state_next = S_SHIFT_INS;
                    else
                        state_next = S_DONE;
                end
                else if (qk == IW'(t_reg))
                begin
                    if (cmd_reg == CMD_EN && !ins_reg)
                        state_next = S_SHIFT_DEL;
                    else
                        state_next = S_DONE;
                end
            end
            S_SHIFT_INS:
                if (idx_reg == pos_reg)
                    state_next = S_DONE;
            S_SHIFT_DEL:
                if (!(idx_reg + QW'(1) < len_reg))
                    state_next = S_DONE;
            S_DONE:
                if (out_free)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    // Datapath updates
    always_comb
    begin
        period_next  = period_reg;
        prio_next    = prio_reg;
        runm_next    = runm_reg;
        lastrun_next = lastrun_reg;
        intv_next    = intv_reg;
        queue_next   = queue_reg;
        len_next     = len_reg;
        cmd_next     = cmd_reg;
        t_next       = t_reg;
        en_next      = en_reg;
        per_next     = per_reg;
        pri_next     = pri_reg;
        run_next     = run_reg;
        now_next     = now_reg;
        idx_next     = idx_reg;
        pos_next     = pos_reg;
        found_next   = found_reg;
        ins_next     = ins_reg;
        prit_next    = prit_reg;
        acc_next     = acc_reg;
        skip_next    = skip_reg;
        k_next       = k_reg;
        rstat_next   = rstat_reg;
        rchos_next   = rchos_reg;
        rdisp_next   = rdisp_reg;
        rq_next      = rq_reg;
        rper_next    = rper_reg;
        rdel_next    = rdel_reg;
        oval_next    = oval_reg & ~m_tready;
        odata_next   = odata_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                // Latch the item and clear the pending result
                if (accept)
                begin
                    cmd_next   = s_tuser;
                    t_next     = s_tdata[3:0];
                    en_next    = s_tdata[4];
                    per_next   = s_tdata[36:5];
                    pri_next   = s_tdata[44:37];
                    run_next   = s_tdata[45];
                    now_next   = s_tdata[77:46];
                    rstat_next = ST_DONE;
                    rchos_next = 4'd0;
                    rdisp_next = 1'b0;
                    rq_next    = 1'b0;
                    rper_next  = 32'd0;
                    rdel_next  = 32'd0;
                end
            end
            S_DECODE:
            begin
                idx_next   = '0;
                pos_next   = len_reg;
                found_next = 1'b0;
                skip_next  = 1'b0;
                ins_next   = en_reg & runm_reg[addr];
                prit_next  = prio_reg[addr];
                if (cmd_reg == CMD_TICK)
                begin
                    if (loop_bad)
                        rstat_next = ST_BADIDX;
                end
                else if (t_bad)
                    rstat_next = ST_BADIDX;
                else if (cmd_reg == CMD_SET)
                begin
                    period_next[addr] = per_reg;
                    prio_next[addr]   = pri_reg;
                    runm_next[addr]   = run_reg;
                end
                else if (cmd_reg == CMD_EN)
                begin
                    if (en_reg && runm_reg[addr] && len_reg >= QW'(DEPTH))
                        rstat_next = ST_NOCHG;
                end
                else
                begin
                    rchos_next = t_reg;
                    rper_next  = period_reg[addr];
                    rdel_next  = intv_reg[addr];
                end
            end
            S_L_SUM, S_L_DIFF:
                acc_next = alu_y;
            S_L_GUARD:
                ;
            S_L_WIN:
                skip_next = alu_borrow & (int'(att_reg) < NUM_TASKS);
            S_L_RUN:
            begin
                // Run the loop task
                intv_next[addr]    = alu_y;
                lastrun_next[addr] = now_reg;
                rchos_next         = loop_reg;
                rdisp_next         = 1'b1;
                rdel_next          = alu_y;
            end
            S_W_FETCH:
            begin
                k_next = qk;
                if (idx_reg != len_reg && skip_reg && 4'(qk) == att_reg)
                    idx_next = idx_reg + QW'(1);
            end
            S_W_SUB:
                acc_next = alu_y;
            S_W_CMP:
            begin
                // Dispatch when elapsed time reaches the period, else advance
                if (!alu_borrow)
                begin
                    intv_next[addr]    = acc_reg;
                    lastrun_next[addr] = now_reg;
                    rchos_next         = 4'(k_reg);
                    rdisp_next         = 1'b1;
                    rdel_next          = acc_reg;
                end
                else
                    idx_next = idx_reg + QW'(1);
            end
            S_SCAN:
            begin
                if (idx_reg == len_reg)
                begin
                    if (cmd_reg == CMD_EN && ins_reg)
                    begin
                        if (pos_reg == len_reg)
                        begin
                            queue_next[len_reg[IW-1:0]] = IW'(t_reg);
                            len_next = len_reg + QW'(1);
                        end
                    end
                    else if (cmd_reg == CMD_EN)
                        rstat_next = ST_NOCHG;
                end
                else if (qk == IW'(t_reg))
                begin
                    if (cmd_reg == CMD_QUERY)
                        rq_next = 1'b1;
                    else if (ins_reg)
                        rstat_next = ST_NOCHG;
                end
                else
                begin
                    if (!found_reg && prio_reg[addr] < prit_reg)
                    begin
                        pos_next   = idx_reg;
                        found_next = 1'b1;
                    end
                    idx_next = idx_reg + QW'(1);
                end
            end
            S_SHIFT_INS:
            begin
                // Open a slot at the insert position, one entry a cycle
                if (idx_reg == pos_reg)
                begin
                    queue_next[pos_reg[IW-1:0]] = IW'(t_reg);
                    len_next = len_reg + QW'(1);
                end
                else
                begin
                    queue_next[idx_reg[IW-1:0]] = queue_reg[IW'(idx_reg - QW'(1))];
                    idx_next = idx_reg - QW'(1);
                end
            end
            S_SHIFT_DEL:
            begin
                // Close the gap left by the removed task
                if (idx_reg + QW'(1) < len_reg)
                begin
                    queue_next[idx_reg[IW-1:0]] = queue_reg[IW'(idx_reg + QW'(1))];
                    idx_next = idx_reg + QW'(1);
                end
                else
                    len_next = len_reg - QW'(1);
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    oval_next  = 1'b1;
                    odata_next = {rdel_reg, rper_reg, rq_reg, rdisp_reg, rchos_reg, rstat_reg};
                end
            end
            default:
                ;
        endcase
    end

    // Configuration registers; writes to the system task index are ignored, reset queues the default system task
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            guard_reg  <= GUARD_RESET;
            window_reg <= WINDOW_RESET;
            loop_reg   <= LOOP_RESET;
            att_reg    <= ATT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            priority case (cfg_index)
                REG_GUARD:  guard_reg  <= cfg_data;
                REG_WINDOW: window_reg <= cfg_data;
                REG_LOOP:   loop_reg   <= cfg_data[3:0];
                REG_ATT:    att_reg    <= cfg_data[3:0];
                REG_SYS:    ;
                default:    ;
            endcase
        end
    end

    // Table, queue and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                period_reg[i]  <= '0;
                prio_reg[i]    <= '0;
                runm_reg[i]    <= 1'b0;
                lastrun_reg[i] <= '0;
                intv_reg[i]    <= '0;
                queue_reg[i]   <= (i == 0) ? IW'(SYS_RESET) : '0;
            end
            len_reg      <= LEN_RESET;
            state_reg    <= S_IDLE;
            oval_reg     <= 1'b0;
        end
        else
        begin
            period_reg  <= period_next;
            prio_reg    <= prio_next;
            runm_reg    <= runm_next;
            lastrun_reg <= lastrun_next;
            intv_reg    <= intv_next;
            queue_reg   <= queue_next;
            len_reg     <= len_next;
            state_reg   <= state_next;
            oval_reg    <= oval_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg   <= cmd_next;
        t_reg     <= t_next;
        en_reg    <= en_next;
        per_reg   <= per_next;
        pri_reg   <= pri_next;
        run_reg   <= run_next;
        now_reg   <= now_next;
        idx_reg   <= idx_next;
        pos_reg   <= pos_next;
        found_reg <= found_next;
        ins_reg   <= ins_next;
        prit_reg  <= prit_next;
        acc_reg   <= acc_next;
        skip_reg  <= skip_next;
        k_reg     <= k_next;
        rstat_reg <= rstat_next;
        rchos_reg <= rchos_next;
        rdisp_reg <= rdisp_next;
        rq_reg    <= rq_next;
        rper_reg  <= rper_next;
        rdel_reg  <= rdel_next;
        odata_reg <= odata_next;
    end

endmodule

### sim/tb_periodic_task_dispatcher.sv
// Self-checking testbench for the periodic task dispatcher.
// Drives task commands and register writes, predicts each result, compares on the output stream.
// Depends on ptd_pkg and periodic_task_dispatcher.
module tb_periodic_task_dispatcher
    import ptd_pkg::*;
;

    localparam int N_TASKS = 16;
    localparam int WATCH_LIMIT = 20000;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [3:0]  task_id;
        logic        en;
        logic [31:0] period;
        logic [7:0]  prio;
        logic        runnable;
        logic [31:0] now;
    } cmd_item_t;

    // Highest field first, so status lands in the low bits of the item
    typedef struct packed {
        logic [31:0] delta;
        logic [31:0] period;
        logic        queued;
        logic        dispatched;
        logic [3:0]  chosen;
        logic [1:0]  status;
    } sched_result_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [79:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [71:0] m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [15:0] cfg_data;

    periodic_task_dispatcher #(.NUM_TASKS(N_TASKS)) u_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // Scheduler shadow state
    logic [15:0] guard_us;
    logic [15:0] window_us;
    logic [3:0]  loop_id;
    logic [3:0]  att_id;
    logic [3:0]  sys_id;
    logic [3:0]  run_queue[$];
    logic [31:0] period_tab[N_TASKS];
    logic [7:0]  prio_tab[N_TASKS];
    logic        runnable_tab[N_TASKS];
    logic [31:0] last_run[N_TASKS];
    logic [31:0] last_gap[N_TASKS];

    cmd_item_t     pending_items[$];
    sched_result_t expected_results[$];
    int  error_count;
    int  idle_cycles;
    bit  quiet_phase;
    bit  hold_sender;
    int  send_gap;
    int  recv_gap;
    int  sent_count;

    // Clock
    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    function automatic bit task_queued(logic [3:0] t);
        foreach (run_queue[i])
            if (run_queue[i] == t)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [1:0] enqueue_task(logic [3:0] t);
        int pos;
        if (run_queue.size() >= N_TASKS || task_queued(t))
            return ST_NOCHG;
        pos = run_queue.size();
        foreach (run_queue[i])
            if (prio_tab[run_queue[i]] < prio_tab[t])
            begin
                pos = i;
                break;
            end
        run_queue.insert(pos, t);
        return ST_DONE;
    endfunction

    function automatic logic [1:0] dequeue_task(logic [3:0] t);
        foreach (run_queue[i])
            if (run_queue[i] == t)
            begin
                run_queue.delete(i);
                return ST_DONE;
            end
        return ST_NOCHG;
    endfunction

    function automatic void reset_schedule();
        guard_us = GUARD_RESET;
        window_us = WINDOW_RESET;
        loop_id = LOOP_RESET;
        att_id = ATT_RESET;
        sys_id = SYS_RESET;
        run_queue.delete();
        for (int i = 0; i < N_TASKS; i++)
        begin
            period_tab[i] = '0;
            prio_tab[i] = '0;
            runnable_tab[i] = 1'b0;
            last_run[i] = '0;
            last_gap[i] = '0;
        end
        void'(enqueue_task(sys_id));
    endfunction

    // Work out the result of one command and advance the shadow state
    function automatic sched_result_t schedule_step(cmd_item_t it);
        sched_result_t r;
        logic [31:0] slack;
        logic [3:0]  k;
        r = '0;
        if (it.cmd == CMD_TICK)
        begin
            slack = last_run[loop_id] + period_tab[loop_id] - it.now;
            if (slack == 0 || slack[31])
            begin
                last_gap[loop_id] = it.now - last_run[loop_id];
                last_run[loop_id] = it.now;
                r.chosen = loop_id;
                r.dispatched = 1'b1;
                r.delta = last_gap[loop_id];
            end
            else if (slack > guard_us)
            begin
                foreach (run_queue[i])
                begin
                    k = run_queue[i];
                    if (k == att_id && slack < window_us)
                        continue;
                    if (it.now - last_run[k] >= period_tab[k])
                    begin
                        last_gap[k] = it.now - last_run[k];
                        last_run[k] = it.now;
                        r.chosen = k;
                        r.dispatched = 1'b1;
                        r.delta = last_gap[k];
                        break;
                    end
                end
            end
        end
        else if (it.cmd == CMD_SET)
        begin
            period_tab[it.task_id] = it.period;
            prio_tab[it.task_id] = it.prio;
            runnable_tab[it.task_id] = it.runnable;
        end
        else if (it.cmd == CMD_EN)
        begin
            if (it.en && runnable_tab[it.task_id])
                r.status = enqueue_task(it.task_id);
            else
                r.status = dequeue_task(it.task_id);
        end
        else
        begin
            r.chosen = it.task_id;
            r.queued = task_queued(it.task_id);
            r.period = period_tab[it.task_id];
            r.delta = last_gap[it.task_id];
        end
        return r;
    endfunction

    // Driver: present queued commands with random gaps
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
            send_gap = 0;
            sent_count = 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                expected_results.push_back(schedule_step(pending_items.pop_front()));
                sent_count++;
            end
            if (!s_tvalid || s_tready)
            begin
                if (send_gap > 0)
                    send_gap--;
                else if (!quiet_phase && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 5);
                if (send_gap == 0 && !hold_sender && pending_items.size() > 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tuser <= pending_items[0].cmd;
                    s_tdata <= {2'b0, pending_items[0].now, pending_items[0].runnable,
                                pending_items[0].prio, pending_items[0].period,
                                pending_items[0].en, pending_items[0].task_id};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Monitor: compare each result with the oldest prediction
    always @(posedge clk or negedge rst_n)
    begin
        sched_result_t got;
        sched_result_t want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            recv_gap = 0;
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
            if (s_tvalid && s_tready)
                idle_cycles = 0;
            if (m_tvalid && m_tready)
            begin
                idle_cycles = 0;
                got = m_tdata;
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result item %h", m_tdata);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status != want.status)
                    begin
                        $error("status exp %0d got %0d", want.status, got.status);
                        error_count++;
                    end
                    if (got.chosen != want.chosen)
                    begin
                        $error("chosen_task exp %0d got %0d", want.chosen, got.chosen);
                        error_count++;
                    end
                    if (got.dispatched != want.dispatched)
                    begin
                        $error("dispatched exp %0d got %0d", want.dispatched, got.dispatched);
                        error_count++;
                    end
                    if (got.queued != want.queued)
                    begin
                        $error("queued exp %0d got %0d", want.queued, got.queued);
                        error_count++;
                    end
                    if (got.period != want.period)
                    begin
                        $error("task_period_us exp %h got %h", want.period, got.period);
                        error_count++;
                    end
                    if (got.delta != want.delta)
                    begin
                        $error("latest_delta_us exp %h got %h", want.delta, got.delta);
                        error_count++;
                    end
                end
            end
            if (recv_gap > 0)
                recv_gap--;
            else if (!quiet_phase && $urandom_range(0, 5) == 0)
                recv_gap = $urandom_range(1, 5);
            m_tready <= (recv_gap == 0);
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        if (rst_n && idle_cycles >= WATCH_LIMIT)
        begin
            $display("periodic_task_dispatcher regression: fail");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_items.size() > 0 || s_tvalid || expected_results.size() > 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            REG_GUARD:  guard_us = val;
            REG_WINDOW: window_us = val;
            REG_LOOP:   loop_id = val[3:0];
            REG_ATT:    att_id = val[3:0];
            REG_SYS:    sys_id = val[3:0];
            default: ;
        endcase
    endtask

    function automatic cmd_item_t make_item(logic [1:0] c, logic [3:0] t);
        cmd_item_t it;
        it.cmd = c;
        it.task_id = t;
        it.en = $urandom_range(0, 3) != 0;
        it.period = ($urandom_range(0, 7) == 0) ? $urandom() : $urandom_range(0, 3000);
        it.prio = ($urandom_range(0, 1) == 0) ? 8'($urandom_range(0, 3))
                                               : 8'($urandom_range(0, 255));
        it.runnable = $urandom_range(0, 4) != 0;
        it.now = $urandom();
        return it;
    endfunction

    // Random phase: mostly table setup and rising-time ticks, some noise
    task automatic random_phase(int count, ref logic [31:0] clock_us);
        cmd_item_t it;
        int pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            it = make_item(CMD_TICK, 4'($urandom_range(0, N_TASKS - 1)));
            if (pick < 12)
                it.cmd = CMD_SET;
            else if (pick < 30)
                it.cmd = CMD_EN;
            else if (pick < 40)
                it.cmd = CMD_QUERY;
            clock_us += $urandom_range(0, 600);
            if (it.cmd == CMD_TICK && $urandom_range(0, 19) != 0)
                it.now = clock_us;
            pending_items.push_back(it);
        end
    endtask

    initial
    begin
        cmd_item_t it;
        logic [31:0] clock_us;
        error_count = 0;
        quiet_phase = 1'b0;
        hold_sender = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        m_tready = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        rst_n = 1'b0;
        reset_schedule();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: field extremes, every command, non-runnable enable, set on queued task
        pending_items.push_back('{CMD_QUERY, 4'd2, 1'b0, 32'd0, 8'd0, 1'b0, 32'd0});
        pending_items.push_back('{CMD_TICK, 4'd0, 1'b0, 32'd0, 8'd0, 1'b0, 32'd0});
        pending_items.push_back('{CMD_SET, 4'd15, 1'b1, 32'hFFFF_FFFF, 8'hFF, 1'b1,
                                  32'hFFFF_FFFF});
        pending_items.push_back('{CMD_SET, 4'd0, 1'b0, 32'd1000, 8'd9, 1'b1, 32'd0});
        pending_items.push_back('{CMD_SET, 4'd1, 1'b0, 32'd0, 8'd5, 1'b1, 32'd0});
        pending_items.push_back('{CMD_SET, 4'd3, 1'b0, 32'd10, 8'd5, 1'b0, 32'd0});
        pending_items.push_back('{CMD_EN, 4'd3, 1'b1, 32'd0, 8'd0, 1'b0, 32'd0});
        pending_items.push_back('{CMD_EN, 4'd15, 1'b1, 32'd0, 8'd0, 1'b0, 32'd0});
        pending_items.push_back('{CMD_EN, 4'd15, 1'b1, 32'd0, 8'd0, 1'b0, 32'd0});
        pending_items.push_back('{CMD_EN, 4'd1, 1'b1, 32'd0, 8'd0, 1'b0, 32'd0});
        pending_items.push_back('{CMD_SET, 4'd15, 1'b0, 32'd5, 8'd0, 1'b0, 32'd0});
        pending_items.push_back('{CMD_TICK, 4'd0, 1'b0, 32'd0, 8'd0, 1'b0, 32'd1000});
        pending_items.push_back('{CMD_TICK, 4'd0, 1'b0, 32'd0, 8'd0, 1'b0, 32'd1300});
        pending_items.push_back('{CMD_TICK, 4'd0, 1'b0, 32'd0, 8'd0, 1'b0, 32'd1500});
        pending_items.push_back('{CMD_TICK, 4'd0, 1'b0, 32'd0, 8'd0, 1'b0, 32'h8000_0000});
        pending_items.push_back('{CMD_QUERY, 4'd15, 1'b0, 32'd0, 8'd0, 1'b0, 32'd0});
        pending_items.push_back('{CMD_EN, 4'd1, 1'b0, 32'd0, 8'd0, 1'b0, 32'd0});
        pending_items.push_back('{CMD_EN, 4'd1, 1'b0, 32'd0, 8'd0, 1'b0, 32'd0});
        pending_items.push_back('{CMD_QUERY, 4'd0, 1'b0, 32'd0, 8'd0, 1'b0, 32'd0});
        wait_drained();

        // Fill the queue to capacity, then overflow
        for (int i = 0; i < N_TASKS; i++)
        begin
            it = make_item(CMD_SET, 4'(i));
            it.runnable = 1'b1;
            pending_items.push_back(it);
            it.cmd = CMD_EN;
            it.en = 1'b1;
            pending_items.push_back(it);
        end
        clock_us = 32'd5000;
        random_phase(400, clock_us);
        wait_drained();

        // Extreme register settings
        write_reg(REG_GUARD, 16'd0);
        write_reg(REG_WINDOW, 16'hFFFF);
        write_reg(REG_LOOP, 16'd15);
        write_reg(REG_ATT, 16'd0);
        write_reg(REG_SYS, 16'd15);
        random_phase(450, clock_us);

        // Hold the sender mid-stream until all results are back
        repeat (200) @(posedge clk);
        hold_sender = 1'b1;
        while (s_tvalid || expected_results.size() > 0)
            @(posedge clk);
        hold_sender = 1'b0;
        wait_drained();

        write_reg(REG_GUARD, 16'hFFFF);
        write_reg(REG_WINDOW, 16'd0);
        write_reg(REG_LOOP, 16'd7);
        write_reg(REG_ATT, 16'd15);
        write_reg(REG_SYS, 16'd0);
        random_phase(450, clock_us);
        wait_drained();

        write_reg(REG_GUARD, 16'd200);
        write_reg(REG_WINDOW, 16'd700);
        write_reg(REG_LOOP, 16'd3);
        write_reg(REG_ATT, 16'd4);
        random_phase(300, clock_us);

        // No idling in the tail
        wait_drained();
        quiet_phase = 1'b1;
        random_phase(200, clock_us);
        wait_drained();

        if (error_count == 0)
            $display("periodic_task_dispatcher regression: pass");
        else
            $display("periodic_task_dispatcher regression: fail");
        $finish;
    end
endmodule

### periodic_task_dispatcher.f
sv/ptd_pkg.sv
sv/ptd_alu.sv
sv/periodic_task_dispatcher.sv
sim/tb_periodic_task_dispatcher.sv
